// ===== design/two_list_sorted_merge_defines.svh =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: assertion macros
// Shared concurrent assertion forms used by the merge block's back end.
// ----------------------------------------------------------------------------
`ifndef TWO_LIST_SORTED_MERGE_DEFINES_SVH
`define TWO_LIST_SORTED_MERGE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define TLSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define TLSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: package
// Beat types, command codes and default sizes shared by the merge block.
// ----------------------------------------------------------------------------
package tlsm_pkg;

    localparam int LIST_DEPTH_DEF = 128;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int Q_DEPTH        = 2;

    typedef enum logic [1:0] {
        KIND_LOAD_FIRST  = 2'd0,
        KIND_LOAD_SECOND = 2'd1,
        KIND_EMIT        = 2'd2,
        KIND_CLEAR       = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic               from_second;
        logic               last;
        logic               empty_res;
        logic               overflow;
    } t_out_beat;

endpackage

// ===== design/tlsm_front.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: front end
// Accepts input beats, decodes the kind, fits the value to the store
// width and queues the command for the back end.
// ----------------------------------------------------------------------------
module tlsm_front #(
    parameter int DATA_WIDTH = tlsm_pkg::DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  tlsm_pkg::t_in_beat     i_in_data,
    output logic                   o_cmd_valid,
    output tlsm_pkg::t_kind        o_cmd,
    output logic [DATA_WIDTH-1:0]  o_cmd_value,
    input  logic                   i_cmd_pop
);
    import tlsm_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_kind                  r_q_cmd [Q_DEPTH];
    logic [DATA_WIDTH-1:0]  r_q_val [Q_DEPTH];
    logic [PW-1:0]          r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]          r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   push;
    logic                   pop;
    logic [63:0]            value_ext;

    // Sign-extend the 32-bit value, then keep the store width.
    assign value_ext = 64'(i_in_data.value);

    assign o_in_stall  = (r_cnt == CW'(Q_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q_cmd[r_rd_ptr];
    assign o_cmd_value = r_q_val[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wr_ptr] <= t_kind'(i_in_data.kind);
            r_q_val[r_wr_ptr] <= value_ext[DATA_WIDTH-1:0];
        end
    end

endmodule

// ===== design/tlsm_back.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge: back end
// Holds both list stores, counts and read positions, executes queued
// commands and drives the registered result beat.
// ----------------------------------------------------------------------------
`include "two_list_sorted_merge_defines.svh"

module tlsm_back #(
    parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = tlsm_pkg::DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  tlsm_pkg::t_kind        i_cmd,
    input  logic [DATA_WIDTH-1:0]  i_cmd_value,
    output logic                   o_cmd_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output tlsm_pkg::t_out_beat    o_out_data
);
    import tlsm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CMP  = 2'b10
    } t_state;

    logic [DATA_WIDTH-1:0]        r_first_mem  [LIST_DEPTH];
    logic [DATA_WIDTH-1:0]        r_second_mem [LIST_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_first_head;
    logic signed [DATA_WIDTH-1:0] r_second_head;

    t_state        r_state, n_state;
    logic [CW-1:0] r_first_count, n_first_count;
    logic [CW-1:0] r_second_count, n_second_count;
    logic [CW-1:0] r_first_pos, n_first_pos;
    logic [CW-1:0] r_second_pos, n_second_pos;
    logic          r_out_valid, n_out_valid;
    t_out_beat     r_out, n_out;

    logic                  wr_first;
    logic                  wr_second;
    logic                  out_free;
    logic                  have_first;
    logic                  have_second;
    logic                  take_second;
    logic [DATA_WIDTH-1:0] pick;
    logic [63:0]           pick_ext;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign have_first  = (r_first_pos < r_first_count);
    assign have_second = (r_second_pos < r_second_count);
    // Ties go to the first list, so the merge stays stable.
    assign take_second = have_second && (!have_first || (r_second_head < r_first_head));
    assign pick        = take_second ? r_second_head : r_first_head;
    assign pick_ext    = 64'($unsigned(pick));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state        = r_state;
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_first_pos    = r_first_pos;
        n_second_pos   = r_second_pos;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out          = r_out;
        wr_first       = 1'b0;
        wr_second      = 1'b0;
        o_cmd_pop      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd)
                        KIND_LOAD_FIRST: begin
                            if (r_first_count < CW'(LIST_DEPTH)) begin
                                wr_first      = 1'b1;
                                n_first_count = r_first_count + CW'(1);
                                o_cmd_pop     = 1'b1;
                            end else if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.overflow = 1'b1;
                                o_cmd_pop   = 1'b1;
                            end
                        end
                        KIND_LOAD_SECOND: begin
                            if (r_second_count < CW'(LIST_DEPTH)) begin
                                wr_second      = 1'b1;
                                n_second_count = r_second_count + CW'(1);
                                o_cmd_pop      = 1'b1;
                            end else if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.overflow = 1'b1;
                                o_cmd_pop   = 1'b1;
                            end
                        end
                        KIND_EMIT: begin
                            if (have_first || have_second) begin
                                n_state = ST_CMP;
                            end else if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.empty_res = 1'b1;
                                o_cmd_pop   = 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            n_first_count  = '0;
                            n_second_count = '0;
                            n_first_pos    = '0;
                            n_second_pos   = '0;
                            o_cmd_pop      = 1'b1;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                // The head registers now hold both lists' next entries.
                if (out_free) begin
                    if (take_second) begin
                        n_second_pos = r_second_pos + CW'(1);
                    end else begin
                        n_first_pos = r_first_pos + CW'(1);
                    end
                    n_out_valid            = 1'b1;
                    n_out.merged_value     = pick_ext[31:0];
                    n_out.from_second      = take_second;
                    n_out.last             = (n_first_pos >= r_first_count)
                                             && (n_second_pos >= r_second_count);
                    n_out.empty_res        = 1'b0;
                    n_out.overflow         = 1'b0;
                    o_cmd_pop              = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_first_pos    <= '0;
            r_second_pos   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_first_count  <= n_first_count;
            r_second_count <= n_second_count;
            r_first_pos    <= n_first_pos;
            r_second_pos   <= n_second_pos;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_first) begin
            r_first_mem[r_first_count[AW-1:0]] <= i_cmd_value;
        end
        r_first_head <= r_first_mem[r_first_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_second) begin
            r_second_mem[r_second_count[AW-1:0]] <= i_cmd_value;
        end
        r_second_head <= r_second_mem[r_second_pos[AW-1:0]];
    end

    `TLSM_ASSERT_NOW(a_first_count_max, i_clk, i_rst_n, 1'b1,
        (r_first_count <= CW'(LIST_DEPTH)) && (r_second_count <= CW'(LIST_DEPTH)),
        "list count exceeds store depth")
    `TLSM_ASSERT_NOW(a_pos_le_count, i_clk, i_rst_n, 1'b1,
        (r_first_pos <= r_first_count) && (r_second_pos <= r_second_count),
        "read position ran past list count")
    `TLSM_ASSERT_NOW(a_cmp_is_emit, i_clk, i_rst_n, r_state == ST_CMP,
        i_cmd_valid && (i_cmd == KIND_EMIT),
        "compare state without an emit at the queue head")
    `TLSM_ASSERT_NOW(a_cmp_has_data, i_clk, i_rst_n, r_state == ST_CMP,
        have_first || have_second,
        "compare state with both lists exhausted")

endmodule

// ===== design/two_list_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// Two-list sorted merge
// Stable merge of two ascending lists of signed integers, one value per emit.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): each beat carries a
// kind and a value. Kind load-first or load-second appends the value to that
// list, emit asks for the next merged value, clear empties both lists.
// Output channel (o_out_valid / i_out_stall / o_out_data): one beat per emit
// and one per load dropped because its list was full; other beats give none.
// Input beats pass a two-entry command queue, so the sender keeps going while
// the back end works or the receiver stalls, until the queue is full.
// A load or clear is done in the back end's idle state, and so is an emit that
// finds both lists exhausted. An emit that finds a value also needs the compare
// state: the idle state reads both list heads from the synchronous-read stores,
// the compare state compares them and registers the result. Loads to a list
// with room therefore stream at one beat per cycle unless an emit holds the
// back end; it takes no new command until a merging emit is done. The result
// of a merging emit is registered after the idle and the compare state.
// Reset (synchronous, active low) empties both lists, the queue and the
// output register. A stall on the output holds the result beat; commands that
// need the output then wait, the queue fills and o_in_stall rises.
// ----------------------------------------------------------------------------
module two_list_sorted_merge #(
    parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = tlsm_pkg::DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tlsm_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tlsm_pkg::t_out_beat o_out_data
);
    import tlsm_pkg::*;

    // Command path from the front end's queue head to the back end.
    logic                  cmd_valid;
    t_kind                 cmd;
    logic [DATA_WIDTH-1:0] cmd_value;
    logic                  cmd_pop;

    // The front end decodes each beat and queues it as a command.
    tlsm_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .o_cmd_value (cmd_value),
        .i_cmd_pop   (cmd_pop)
    );

    // The back end owns the stores and pops a command once it is done.
    tlsm_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .i_cmd_value (cmd_value),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
